// ===== rtl/core/sorted_list_insert_delete_assert.svh =====
// Assertion macros for the sorted list core.
// Depends on aclk and aresetn being visible in the module that uses them.
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define SLI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SLI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sli_pkg.sv =====
// Shared types and codes for the sorted list core.
// Used by sli_cell and sorted_list_insert_delete; no dependencies.
package sli_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                      cmp_en;
        logic                      ins_en;
        logic                      del_en;
        logic signed [VALUE_W-1:0] value;
    } cell_ctl_t;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic signed [VALUE_W-1:0] entry;
        logic                      occ;
        logic                      le;
        logic                      eq;
    } nbr_t;

endpackage

// ===== rtl/core/sli_cell.sv =====
// One cell of the sorted list: an entry, its compare flags and shift logic.
// Depends on sli_pkg.
module sli_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sli_pkg::cell_ctl_t ctl,
    input  logic [CW-1:0]      count,
    input  sli_pkg::nbr_t      below,
    input  sli_pkg::nbr_t      above,
    output sli_pkg::nbr_t      me,
    output logic               ins_mark,
    output logic               del_mark
);

    logic signed [sli_pkg::VALUE_W-1:0] entry_reg;
    logic                               occ_reg;
    logic                               le_reg;
    logic                               eq_reg;
    logic                               occ_now;
    logic                               shift_up;
    logic                               shift_dn;

    assign occ_now  = CW'(INDEX) < count;
    // List is sorted, so le flags form a prefix and eq flags a contiguous run.
    assign ins_mark = !le_reg && below.le;
    assign shift_up = !below.le && below.occ;
    assign del_mark = eq_reg && !above.eq;
    assign shift_dn = del_mark || (occ_reg && !le_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
            le_reg  <= 1'b0;
            eq_reg  <= 1'b0;
        end else if (ctl.cmp_en) begin
            occ_reg <= occ_now;
            le_reg  <= occ_now && (entry_reg <= ctl.value);
            eq_reg  <= occ_now && (entry_reg == ctl.value);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ins_en) begin
            if (shift_up) begin
                entry_reg <= below.entry;
            end else if (ins_mark) begin
                entry_reg <= ctl.value;
            end
        end else if (ctl.del_en && shift_dn) begin
            entry_reg <= above.entry;
        end
    end

    assign me.entry = entry_reg;
    assign me.occ   = occ_reg;
    assign me.le    = le_reg;
    assign me.eq    = eq_reg;

endmodule

// ===== rtl/core/sli_enc.sv =====
// One-hot to binary encoder over the cell marks, with an any-set flag.
// Depends on nothing.
module sli_enc #(
    parameter int N = 16,
    parameter int W = 4
) (
    input  logic [N-1:0] onehot,
    output logic [W-1:0] idx,
    output logic         any
);

    always_comb begin
        idx = '0;
        for (int i = 0; i < N; i++) begin
            if (onehot[i]) begin
                idx = idx | W'(i);
            end
        end
    end

    assign any = |onehot;

endmodule

// ===== rtl/core/sorted_list_insert_delete.sv =====
// Sorted list of signed 32-bit values held in a row of compare/shift cells.
// Depends on sli_pkg, sli_cell, sli_enc and sorted_list_insert_delete_assert.svh.
//
// Input stream (s_*): one transaction carries action, value and index.
//   action insert places the value above all equal entries, delete removes
//   the highest-placed equal entry, read returns the entry at index.
// Result stream (m_*): exactly one transaction per input transaction with
//   status, position, the count after the operation and the read value.
// Timing: an input is taken only while the block is idle. The next cycle
//   every cell compares its entry with the value in parallel; then, once the
//   output register is free, the cells shift one place toward or away from
//   their neighbor on an insert or delete and the result is loaded into the
//   output register. A new input is taken only after that result is loaded.
//   The compare and shift steps in the cell row set this sequence.
// Reset (aresetn low, synchronous) empties the list and drops any pending
//   result; entry contents are not cleared.
// A stalled receiver holds the result in the output register; a new input
//   is still taken and compared, and its shift waits until the result leaves.
module sorted_list_insert_delete #(
    parameter int  DEPTH  = sli_pkg::DEPTH_DEF,
    localparam int PW     = $clog2(DEPTH),
    localparam int CW     = $clog2(DEPTH + 1),
    localparam int IN_W   = sli_pkg::ACTION_W + sli_pkg::VALUE_W + PW,
    localparam int IN_DW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = sli_pkg::STATUS_W + PW + CW + sli_pkg::VALUE_W,
    localparam int OUT_DW = ((OUT_W + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_DW-1:0]  s_tdata,   // action, value, index
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata    // status, position, count, read_value
);

    `include "sorted_list_insert_delete_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    state_t                             state_reg;
    logic [sli_pkg::ACTION_W-1:0]       op_action_reg;
    logic signed [sli_pkg::VALUE_W-1:0] op_value_reg;
    logic [PW-1:0]                      op_index_reg;
    logic [CW-1:0]                      count_reg;
    logic                               m_tvalid_reg;
    logic [sli_pkg::STATUS_W-1:0]       status_reg;
    logic [PW-1:0]                      pos_reg;
    logic [CW-1:0]                      cnt_out_reg;
    logic signed [sli_pkg::VALUE_W-1:0] rdv_reg;

    logic [sli_pkg::STATUS_W-1:0]       status_next;
    logic [PW-1:0]                      pos_next;
    logic [CW-1:0]                      count_next;
    logic signed [sli_pkg::VALUE_W-1:0] rdv_next;

    sli_pkg::cell_ctl_t ctl;
    sli_pkg::nbr_t      nb [DEPTH];
    sli_pkg::nbr_t      edge_lo;
    logic [DEPTH-1:0]   ins_marks;
    logic [DEPTH-1:0]   del_marks;
    logic [PW-1:0]      ins_pos;
    logic [PW-1:0]      del_pos;
    logic               ins_any;
    logic               found;

    logic in_acc;
    logic exec_go;
    logic is_read;
    logic is_insert;
    logic full;
    logic rd_ok;

    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign exec_go   = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);
    assign is_read   = (op_action_reg & sli_pkg::ACT_READ) != '0;
    assign is_insert = (op_action_reg == sli_pkg::ACT_INSERT);
    assign full      = (count_reg == CW'(DEPTH));
    assign rd_ok     = CW'(op_index_reg) < count_reg;

    assign ctl.cmp_en = (state_reg == S_CMP);
    assign ctl.ins_en = exec_go && !is_read && is_insert && !full;
    assign ctl.del_en = exec_go && !is_read && !is_insert && found;
    assign ctl.value  = op_value_reg;

    // Below cell 0 sits an always-less-or-equal neighbor with nothing to shift in.
    assign edge_lo.entry = '0;
    assign edge_lo.occ   = 1'b0;
    assign edge_lo.le    = 1'b1;
    assign edge_lo.eq    = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        sli_pkg::nbr_t below_i;
        sli_pkg::nbr_t above_i;

        if (i == 0) begin : g_lo
            assign below_i = edge_lo;
        end else begin : g_mid_lo
            assign below_i = nb[i-1];
        end

        if (i == DEPTH - 1) begin : g_hi
            assign above_i.entry = nb[i].entry;
            assign above_i.occ   = 1'b0;
            assign above_i.le    = 1'b0;
            assign above_i.eq    = 1'b0;
        end else begin : g_mid_hi
            assign above_i = nb[i+1];
        end

        sli_cell #(
            .INDEX(i),
            .CW   (CW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .count   (count_reg),
            .below   (below_i),
            .above   (above_i),
            .me      (nb[i]),
            .ins_mark(ins_marks[i]),
            .del_mark(del_marks[i])
        );
    end

    sli_enc #(.N(DEPTH), .W(PW)) u_ins_enc (
        .onehot(ins_marks),
        .idx   (ins_pos),
        .any   (ins_any)
    );

    sli_enc #(.N(DEPTH), .W(PW)) u_del_enc (
        .onehot(del_marks),
        .idx   (del_pos),
        .any   (found)
    );

    always_comb begin
        status_next = sli_pkg::ST_OK;
        pos_next    = '0;
        count_next  = count_reg;
        rdv_next    = '0;
        if (is_read) begin
            if (rd_ok) begin
                pos_next = op_index_reg;
                rdv_next = nb[op_index_reg].entry;
            end else begin
                status_next = sli_pkg::ST_BAD_INDEX;
            end
        end else if (is_insert) begin
            if (full) begin
                status_next = sli_pkg::ST_FULL;
            end else begin
                pos_next   = ins_pos;
                count_next = count_reg + CW'(1);
            end
        end else begin
            if (found) begin
                pos_next   = del_pos;
                count_next = count_reg - CW'(1);
            end else begin
                status_next = sli_pkg::ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (exec_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    // Hold until the output register is free.
                    if (exec_go) begin
                        state_reg <= S_IDLE;
                        count_reg <= count_next;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            op_action_reg <= s_tdata[sli_pkg::ACTION_W-1:0];
            op_value_reg  <= s_tdata[sli_pkg::ACTION_W +: sli_pkg::VALUE_W];
            op_index_reg  <= s_tdata[sli_pkg::ACTION_W + sli_pkg::VALUE_W +: PW];
        end
        if (exec_go) begin
            status_reg  <= status_next;
            pos_reg     <= pos_next;
            cnt_out_reg <= count_next;
            rdv_reg     <= rdv_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DW'({rdv_reg, cnt_out_reg, pos_reg, status_reg});

    `SLI_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "count exceeds depth")
    `SLI_ASSERT_SAME(a_ins_onehot, state_reg == S_EXEC, $onehot0(ins_marks), "several insert points")
    `SLI_ASSERT_SAME(a_del_onehot, state_reg == S_EXEC, $onehot0(del_marks), "several delete points")
    `SLI_ASSERT_SAME(a_ins_point, ctl.ins_en, ins_any, "insert with no insert point")
    `SLI_ASSERT_NEXT(a_one_at_once, in_acc, !s_tready, "input taken while busy")

endmodule
